[rtl/rgb_contrast_stretch_core_macros.svh]
// Assertion macros for the contrast stretch core.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef RGB_CONTRAST_STRETCH_CORE_MACROS_SVH
`define RGB_CONTRAST_STRETCH_CORE_MACROS_SVH

`ifndef SYNTH
`define RCS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rgb_contrast_stretch_core: invariant violated");
`define RCS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb_contrast_stretch_core: implication violated");
`define RCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgb_contrast_stretch_core: next-cycle check violated");
`else
`define RCS_ASSERT_ALWAYS(label, cond)
`define RCS_ASSERT_IMPLY(label, ante, cons)
`define RCS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/rcs_pkg.sv]
package rcs_pkg;

    localparam int PIX_W          = 8;
    localparam int STEP_W         = $clog2(PIX_W);
    localparam int NUM_COLORS     = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [PIX_W-1:0] LEVEL_TOP    = 8'd255;
    localparam logic [PIX_W-1:0] LEVEL_BOTTOM = 8'd0;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_MAP     = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
        logic [PIX_W-1:0] level_min;
        logic [PIX_W-1:0] level_max;
    } map_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[rtl/rgb_contrast_stretch_core.sv]
// Min-max contrast stretch of RGBA pixels in two passes. Measure transactions
// (operation 0) fold red, green and blue into one shared minimum and maximum;
// frame_start on a measure restarts them. Map transactions (operation 1) yield
// (v - min) * 255 / (max - min) per color, clamped to 0..255, with alpha copied;
// a flat or empty range gives 0. Measure transactions are taken one per clock
// while the queue is not full. Each map transaction snapshots the statistics
// at acceptance and waits in a QUEUE_DEPTH-entry queue; the back end runs one
// restoring divider per color, one quotient bit per cycle, and takes a new map
// item from the queue only once the last result has moved to the output register.
// full rises when the queue is full, blocking both kinds of input.
`include "rgb_contrast_stretch_core_macros.svh"

module rgb_contrast_stretch_core
#(
    parameter int QUEUE_DEPTH = rcs_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       operation,
    input  logic                       frame_start,
    input  logic [rcs_pkg::PIX_W-1:0]  red_in,
    input  logic [rcs_pkg::PIX_W-1:0]  green_in,
    input  logic [rcs_pkg::PIX_W-1:0]  blue_in,
    input  logic [rcs_pkg::PIX_W-1:0]  alpha_in,
    output logic                       empty,
    input  logic                       pop,
    output logic [rcs_pkg::PIX_W-1:0]  red_out,
    output logic [rcs_pkg::PIX_W-1:0]  green_out,
    output logic [rcs_pkg::PIX_W-1:0]  blue_out,
    output logic [rcs_pkg::PIX_W-1:0]  alpha_out
);

    rcs_pkg::q_stat_t   q_stat;
    rcs_pkg::map_item_t q_wr_data;
    rcs_pkg::map_item_t q_rd_data;
    logic               q_push;
    logic               q_pop;

    rcs_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .frame_start (frame_start),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .alpha_in    (alpha_in),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_data      (q_wr_data)
    );

    rcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    rcs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_data    (q_rd_data),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out)
    );

    `RCS_ASSERT_ALWAYS(a_queue_stat_exclusive, !(q_stat.full && q_stat.empty))
    `RCS_ASSERT_IMPLY(a_pop_only_when_filled, q_pop, !q_stat.empty)
    `RCS_ASSERT_NEXT(a_map_lands_in_queue, push && !full && (operation == rcs_pkg::OP_MAP), !q_stat.empty)

endmodule

[rtl/rcs_front.sv]
module rcs_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       operation,
    input  logic                       frame_start,
    input  logic [rcs_pkg::PIX_W-1:0]  red_in,
    input  logic [rcs_pkg::PIX_W-1:0]  green_in,
    input  logic [rcs_pkg::PIX_W-1:0]  blue_in,
    input  logic [rcs_pkg::PIX_W-1:0]  alpha_in,
    input  rcs_pkg::q_stat_t           q_stat,
    output logic                       q_push,
    output rcs_pkg::map_item_t         q_data
);

    logic [rcs_pkg::PIX_W-1:0] level_min_reg;
    logic [rcs_pkg::PIX_W-1:0] level_min_next;
    logic [rcs_pkg::PIX_W-1:0] level_max_reg;
    logic [rcs_pkg::PIX_W-1:0] level_max_next;
    logic                      accept;
    logic                      measure;
    logic [rcs_pkg::PIX_W-1:0] base_min;
    logic [rcs_pkg::PIX_W-1:0] base_max;
    logic [rcs_pkg::PIX_W-1:0] rg_min;
    logic [rcs_pkg::PIX_W-1:0] rg_max;
    logic [rcs_pkg::PIX_W-1:0] rgb_min;
    logic [rcs_pkg::PIX_W-1:0] rgb_max;

    assign full    = q_stat.full;
    assign accept  = push && !q_stat.full;
    assign measure = accept && (operation == rcs_pkg::OP_MEASURE);
    assign q_push  = accept && (operation == rcs_pkg::OP_MAP);

    // Map items carry the statistics as they stand at acceptance.
    assign q_data.red       = red_in;
    assign q_data.green     = green_in;
    assign q_data.blue      = blue_in;
    assign q_data.alpha     = alpha_in;
    assign q_data.level_min = level_min_reg;
    assign q_data.level_max = level_max_reg;

    always_comb
    begin
        base_min = frame_start ? rcs_pkg::LEVEL_TOP    : level_min_reg;
        base_max = frame_start ? rcs_pkg::LEVEL_BOTTOM : level_max_reg;
        rg_min   = (red_in < green_in) ? red_in : green_in;
        rg_max   = (red_in > green_in) ? red_in : green_in;
        rgb_min  = (blue_in < rg_min) ? blue_in : rg_min;
        rgb_max  = (blue_in > rg_max) ? blue_in : rg_max;

        level_min_next = level_min_reg;
        level_max_next = level_max_reg;
        if (measure)
        begin
            level_min_next = (rgb_min < base_min) ? rgb_min : base_min;
            level_max_next = (rgb_max > base_max) ? rgb_max : base_max;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_min_reg <= rcs_pkg::LEVEL_TOP;
            level_max_reg <= rcs_pkg::LEVEL_BOTTOM;
        end
        else
        begin
            level_min_reg <= level_min_next;
            level_max_reg <= level_max_next;
        end
    end

endmodule

[rtl/rcs_queue.sv]
module rcs_queue
#(
    parameter int DEPTH = rcs_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  rcs_pkg::map_item_t wr_data,
    input  logic               rd_en,
    output rcs_pkg::map_item_t rd_data,
    output rcs_pkg::q_stat_t   stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rcs_pkg::map_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_wr;
    logic               do_rd;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/rcs_back.sv]
module rcs_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  rcs_pkg::q_stat_t           q_stat,
    input  rcs_pkg::map_item_t         q_data,
    output logic                       q_pop,
    output logic                       empty,
    input  logic                       pop,
    output logic [rcs_pkg::PIX_W-1:0]  red_out,
    output logic [rcs_pkg::PIX_W-1:0]  green_out,
    output logic [rcs_pkg::PIX_W-1:0]  blue_out,
    output logic [rcs_pkg::PIX_W-1:0]  alpha_out
);

    localparam int W  = rcs_pkg::PIX_W;
    localparam int NC = rcs_pkg::NUM_COLORS;
    localparam int SW = rcs_pkg::STEP_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_HOLD
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [SW-1:0] step_reg;
    logic [SW-1:0] step_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    logic [W-1:0]  rem_reg   [NC];
    logic [W-1:0]  rem_next  [NC];
    logic [W-1:0]  num_reg   [NC];
    logic [W-1:0]  num_next  [NC];
    logic [W-1:0]  div_reg   [NC];
    logic [W-1:0]  div_next  [NC];
    logic [W-1:0]  quo_reg   [NC];
    logic [W-1:0]  quo_next  [NC];
    logic          zero_reg  [NC];
    logic          zero_next [NC];
    logic          sat_reg   [NC];
    logic          sat_next  [NC];
    logic [W-1:0]  alpha_reg;
    logic [W-1:0]  alpha_next;
    logic [W-1:0]  col_out_reg  [NC];
    logic [W-1:0]  col_out_next [NC];
    logic [W-1:0]  alpha_out_reg;
    logic [W-1:0]  alpha_out_next;

    logic [W-1:0]   sample [NC];
    logic [W-1:0]   diff   [NC];
    logic [2*W-1:0] prod   [NC];
    logic [W:0]     trial  [NC];
    logic           ge     [NC];
    logic           load;
    logic           emit;

    assign sample[0] = q_data.red;
    assign sample[1] = q_data.green;
    assign sample[2] = q_data.blue;

    assign load  = (state_reg == ST_IDLE) && !q_stat.empty;
    assign emit  = (state_reg == ST_HOLD) && (!out_valid_reg || pop);
    assign q_pop = load;

    assign empty     = !out_valid_reg;
    assign red_out   = col_out_reg[0];
    assign green_out = col_out_reg[1];
    assign blue_out  = col_out_reg[2];
    assign alpha_out = alpha_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        alpha_next     = alpha_reg;
        alpha_out_next = alpha_out_reg;

        for (int i = 0; i < NC; i++)
        begin
            // (s - min) * 255 as a shift and subtract
            diff[i]  = sample[i] - q_data.level_min;
            prod[i]  = {diff[i], {W{1'b0}}} - {{W{1'b0}}, diff[i]};
            trial[i] = {rem_reg[i], num_reg[i][W-1]};
            ge[i]    = (trial[i] >= {1'b0, div_reg[i]});

            rem_next[i]     = rem_reg[i];
            num_next[i]     = num_reg[i];
            div_next[i]     = div_reg[i];
            quo_next[i]     = quo_reg[i];
            zero_next[i]    = zero_reg[i];
            sat_next[i]     = sat_reg[i];
            col_out_next[i] = col_out_reg[i];

            if (load)
            begin
                zero_next[i] = (q_data.level_max <= q_data.level_min)
                               || (sample[i] <= q_data.level_min);
                sat_next[i]  = (sample[i] >= q_data.level_max);
                // High byte of the dividend is below the divisor when the
                // sample sits under the maximum, so the quotient fits W bits.
                rem_next[i]  = prod[i][2*W-1:W];
                num_next[i]  = prod[i][W-1:0];
                div_next[i]  = q_data.level_max - q_data.level_min;
                quo_next[i]  = '0;
            end
            else if (state_reg == ST_DIVIDE)
            begin
                rem_next[i] = ge[i] ? W'(trial[i] - {1'b0, div_reg[i]}) : trial[i][W-1:0];
                num_next[i] = {num_reg[i][W-2:0], 1'b0};
                quo_next[i] = {quo_reg[i][W-2:0], ge[i]};
            end

            if (emit)
            begin
                col_out_next[i] = zero_reg[i] ? rcs_pkg::LEVEL_BOTTOM :
                                  sat_reg[i]  ? rcs_pkg::LEVEL_TOP    : quo_reg[i];
            end
        end

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    alpha_next = q_data.alpha;
                    step_next  = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(W - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                // hold the result until the output register frees up
                if (emit)
                begin
                    alpha_out_next = alpha_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            alpha_reg     <= alpha_next;
            alpha_out_reg <= alpha_out_next;
            for (int i = 0; i < NC; i++)
            begin
                rem_reg[i]     <= rem_next[i];
                num_reg[i]     <= num_next[i];
                div_reg[i]     <= div_next[i];
                quo_reg[i]     <= quo_next[i];
                zero_reg[i]    <= zero_next[i];
                sat_reg[i]     <= sat_next[i];
                col_out_reg[i] <= col_out_next[i];
            end
        end
    end

endmodule
